// ----- rtl/tptc_pkg.sv -----
// Shared types and constants for the tile pair transition counter.
`default_nettype none
package tptc_pkg;

  localparam int TILE_TYPES_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 20;
  localparam int TILE_BITS_MAX  = 8;
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int PROB_FRAC      = 16;
  localparam logic [16:0] PROB_ONE = 17'h10000;
  localparam logic [10:0] MAP_WIDTH_RESET = 11'd16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] tile_code;
    logic       direction;
    logic [5:0] from_tile;
    logic [5:0] to_tile;
  } in_item_t;

  typedef struct packed {
    logic [16:0] probability;
    logic [19:0] pair_count;
    logic [19:0] row_total;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic                     has_right;
    logic                     has_down;
    logic                     dir;
    logic [TILE_BITS_MAX-1:0] left;
    logic [TILE_BITS_MAX-1:0] above;
    logic [TILE_BITS_MAX-1:0] tile;
    logic [TILE_BITS_MAX-1:0] from_t;
    logic [TILE_BITS_MAX-1:0] to_t;
  } cmd_t;

  typedef enum logic {
    FR_IDLE = 1'b0,
    FR_LOOK = 1'b1
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_UPDATE = 2'd1,
    BK_DIV    = 2'd2,
    BK_CLEAR  = 2'd3
  } bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/tile_pair_transition_counter_core.sv -----
// Tile pair transition counter: top level tying the front, queue and back together.
//
// Items enter through push/full; a transfer happens at a clock edge with push high
// and full low. Results leave through empty/pop: the oldest result sits on out_data
// while empty is low and is transferred at an edge with pop high.
// map_width is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// The front takes a clear or read item every cycle while the queue has room and
// no clear sweep runs; a tile sample holds it off through a line buffer read, then
// a write. The back does a sample as a count table read, then a saturating write.
// A read needs only the count table read when the row total is zero or the count
// reaches it, else also the 16-step radix-2 divider; the result is then registered.
// A clear sweeps all TILE_TYPES*TILE_TYPES pair table entries (4096 by default)
// and the row totals, and full stays high during the sweep.
// After reset the same sweep runs, so full stays high until it ends.
// A waiting result does not stall tile samples; a read stalls in the queue until
// the previous result has been popped, and full rises once the queue fills.
`default_nettype none
module tile_pair_transition_counter_core
  import tptc_pkg::*;
#(
  parameter int TILE_TYPES = TILE_TYPES_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire in_item_t    in_data,
  output logic             full,
  input  wire logic        pop,
  output out_item_t        out_data,
  output logic             empty,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);
  logic [10:0] map_width;
  logic        front_ready;
  logic        q_push;
  cmd_t        q_wdata;
  logic        q_full;
  logic        q_pop;
  cmd_t        q_rdata;
  logic        q_empty;
  logic        busy;

  assign cfg_ready = 1'b1;
  assign full      = !front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= MAP_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      map_width <= cfg_data;
    end
  end

  tptc_front #(
    .TILE_TYPES(TILE_TYPES),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .map_width(map_width),
    .hold     (busy),
    .push     (push),
    .in_data  (in_data),
    .ready    (front_ready),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  tptc_fifo #(
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  tptc_back #(
    .TILE_TYPES(TILE_TYPES),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .busy    (busy),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

// ----- rtl/tptc_fifo.sv -----
// Short command queue between the front and back parts.
`default_nettype none
module tptc_fifo
  import tptc_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tptc_front.sv -----
// Front part: accepts items, tracks the raster position and line buffer, issues commands.
`default_nettype none
module tptc_front
  import tptc_pkg::*;
#(
  parameter int TILE_TYPES = TILE_TYPES_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [10:0] map_width,
  input  wire logic        hold,
  input  wire logic        push,
  input  wire in_item_t    in_data,
  output logic             ready,
  output logic             q_push,
  output cmd_t             q_data,
  input  wire logic        q_full
);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  fr_state_t         state;
  fr_state_t         state_next;
  logic [CW-1:0]     col;
  logic              first_row;
  logic [7:0]        left;
  logic [7:0]        line_mem [MAX_WIDTH];
  logic [7:0]        above_q;
  logic [7:0]        tile_l;
  logic [CW-1:0]     col_l;
  logic              has_right_l;
  logic              has_down_l;
  logic [7:0]        left_l;
  logic              accept;
  logic [7:0]        tile_m;
  logic [WW-1:0]     eff_w;
  logic [13:0]       col_p1;
  logic              row_end;

  // Codes are folded into the table range; at a power of two this is a mask.
  function automatic logic [7:0] fold(input logic [5:0] code);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < 64; j++) begin
      if (code == 6'(j)) begin
        r = 8'(j % TILE_TYPES);
      end
    end
    return r;
  endfunction

  assign ready  = (state == FR_IDLE) && !q_full && !hold;
  assign accept = push && ready;
  assign tile_m = fold(in_data.tile_code);

  always_comb begin
    if (map_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(map_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(map_width);
    end
  end

  assign col_p1  = 14'(col) + 14'd1;
  assign row_end = col_p1 >= 14'(eff_w);

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_SAMPLE) begin
      above_q     <= line_mem[col];
      tile_l      <= tile_m;
      col_l       <= col;
      has_right_l <= (col != '0);
      has_down_l  <= !first_row;
      left_l      <= left;
    end
    if (state == FR_LOOK) begin
      line_mem[col_l] <= tile_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FR_IDLE;
      col       <= '0;
      first_row <= 1'b1;
      left      <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_data.opcode == OP_CLEAR) begin
          col       <= '0;
          first_row <= 1'b1;
          left      <= '0;
        end else if (in_data.opcode == OP_SAMPLE) begin
          left <= tile_m;
          if (row_end) begin
            col       <= '0;
            first_row <= 1'b0;
          end else begin
            col <= CW'(col_p1);
          end
        end
      end
    end
  end

  always_comb begin
    state_next       = state;
    q_push           = 1'b0;
    q_data           = '0;
    q_data.kind      = CMD_CLEAR;
    q_data.dir       = in_data.direction;
    q_data.from_t    = fold(in_data.from_tile);
    q_data.to_t      = fold(in_data.to_tile);
    case (state)
      FR_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_CLEAR: begin
              q_push = 1'b1;
            end
            OP_SAMPLE: begin
              state_next = FR_LOOK;
            end
            OP_READ: begin
              q_push      = 1'b1;
              q_data.kind = CMD_READ;
            end
            default: ;
          endcase
        end
      end
      FR_LOOK: begin
        // The line buffer read issued at acceptance is now available.
        q_push           = 1'b1;
        q_data.kind      = CMD_SAMPLE;
        q_data.has_right = has_right_l;
        q_data.has_down  = has_down_l;
        q_data.left      = left_l;
        q_data.above     = above_q;
        q_data.tile      = tile_l;
        state_next       = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/tptc_back.sv -----
// Back part: count tables, clearing sweep, Q0.16 divider and result register.
`default_nettype none
module tptc_back
  import tptc_pkg::*;
#(
  parameter int TILE_TYPES = TILE_TYPES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_data,
  output logic      q_pop,
  output logic      busy,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_data
);
  localparam int PAIR_DEPTH = TILE_TYPES * TILE_TYPES;
  localparam int TB  = $clog2(TILE_TYPES);
  localparam int PAW = $clog2(PAIR_DEPTH);
  localparam int CB  = COUNT_BITS;

  bk_state_t       state;
  bk_state_t       state_next;
  cmd_t            cmd;
  logic [PAW-1:0]  idx;
  logic [3:0]      div_cnt;
  logic [CB-1:0]   rem;
  logic [15:0]     quo;
  logic [CB-1:0]   tot_l;
  logic [CB-1:0]   cnt_l;
  logic            out_valid;

  logic [CB-1:0]   rp_mem [PAIR_DEPTH];
  logic [CB-1:0]   dp_mem [PAIR_DEPTH];
  logic [CB-1:0]   rt_mem [TILE_TYPES];
  logic [CB-1:0]   dt_mem [TILE_TYPES];
  logic [CB-1:0]   rp_q;
  logic [CB-1:0]   dp_q;
  logic [CB-1:0]   rt_q;
  logic [CB-1:0]   dt_q;

  logic [PAW-1:0]  ra_rp;
  logic [PAW-1:0]  ra_dp;
  logic [TB-1:0]   ra_rt;
  logic [TB-1:0]   ra_dt;
  logic            we_rp, we_dp, we_rt, we_dt;
  logic [PAW-1:0]  wa_rp, wa_dp;
  logic [TB-1:0]   wa_rt, wa_dt;
  logic [CB-1:0]   wd_rp, wd_dp, wd_rt, wd_dt;
  logic [CB-1:0]   sel_cnt;
  logic [CB-1:0]   sel_tot;
  logic [CB:0]     rem2;
  logic            rem_ge;
  logic            ld_out;
  logic [16:0]     ld_prob;
  logic [31:0]     cnt32;
  logic [31:0]     tot32;

  function automatic logic [PAW-1:0] pair_addr(input logic [7:0] a, input logic [7:0] b);
    return PAW'(a[TB-1:0]) * PAW'(TILE_TYPES) + PAW'(b[TB-1:0]);
  endfunction

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == '1) ? v : v + CB'(1);
  endfunction

  assign q_pop = (state == BK_IDLE) && !q_empty &&
                 ((q_data.kind != CMD_READ) || !out_valid);
  assign busy  = (state == BK_CLEAR);
  assign empty = !out_valid;

  always_comb begin
    if (q_data.kind == CMD_SAMPLE) begin
      ra_rp = pair_addr(q_data.left, q_data.tile);
      ra_dp = pair_addr(q_data.above, q_data.tile);
      ra_rt = q_data.left[TB-1:0];
      ra_dt = q_data.above[TB-1:0];
    end else begin
      ra_rp = pair_addr(q_data.from_t, q_data.to_t);
      ra_dp = ra_rp;
      ra_rt = q_data.from_t[TB-1:0];
      ra_dt = q_data.from_t[TB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rp_q <= rp_mem[ra_rp];
      dp_q <= dp_mem[ra_dp];
      rt_q <= rt_mem[ra_rt];
      dt_q <= dt_mem[ra_dt];
    end
    if (we_rp) rp_mem[wa_rp] <= wd_rp;
    if (we_dp) dp_mem[wa_dp] <= wd_dp;
    if (we_rt) rt_mem[wa_rt] <= wd_rt;
    if (we_dt) dt_mem[wa_dt] <= wd_dt;
  end

  assign sel_cnt = cmd.dir ? dp_q : rp_q;
  assign sel_tot = cmd.dir ? dt_q : rt_q;
  assign rem2    = {rem, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, tot_l};

  always_comb begin
    state_next = state;
    we_rp = 1'b0;
    we_dp = 1'b0;
    we_rt = 1'b0;
    we_dt = 1'b0;
    wa_rp = pair_addr(cmd.left, cmd.tile);
    wa_dp = pair_addr(cmd.above, cmd.tile);
    wa_rt = cmd.left[TB-1:0];
    wa_dt = cmd.above[TB-1:0];
    wd_rp = sat_inc(rp_q);
    wd_dp = sat_inc(dp_q);
    wd_rt = sat_inc(rt_q);
    wd_dt = sat_inc(dt_q);
    ld_out  = 1'b0;
    ld_prob = '0;
    case (state)
      BK_IDLE: begin
        if (q_pop) begin
          state_next = (q_data.kind == CMD_CLEAR) ? BK_CLEAR : BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        state_next = BK_IDLE;
        if (cmd.kind == CMD_SAMPLE) begin
          we_rp = cmd.has_right;
          we_rt = cmd.has_right;
          we_dp = cmd.has_down;
          we_dt = cmd.has_down;
        end else if (sel_tot == '0) begin
          ld_out = 1'b1;
        end else if (sel_cnt >= sel_tot) begin
          ld_out  = 1'b1;
          ld_prob = PROB_ONE;
        end else begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_cnt == 4'(PROB_FRAC - 1)) begin
          ld_out     = 1'b1;
          ld_prob    = {1'b0, quo[14:0], rem_ge};
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        we_rp = 1'b1;
        we_dp = 1'b1;
        wa_rp = idx;
        wa_dp = idx;
        wd_rp = '0;
        wd_dp = '0;
        wd_rt = '0;
        wd_dt = '0;
        wa_rt = idx[TB-1:0];
        wa_dt = idx[TB-1:0];
        we_rt = (32'(idx) < TILE_TYPES);
        we_dt = (32'(idx) < TILE_TYPES);
        if (idx == PAW'(PAIR_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (state == BK_UPDATE) begin
      cnt_l   <= sel_cnt;
      tot_l   <= sel_tot;
      rem     <= sel_cnt;
      quo     <= '0;
      div_cnt <= '0;
    end else if (state == BK_DIV) begin
      rem     <= rem_ge ? CB'(rem2 - {1'b0, tot_l}) : CB'(rem2);
      quo     <= {quo[14:0], rem_ge};
      div_cnt <= div_cnt + 4'd1;
    end
  end

  always_comb begin
    cnt32 = 32'(cnt_l);
    tot32 = 32'(tot_l);
    if (state == BK_UPDATE) begin
      cnt32 = 32'(sel_cnt);
      tot32 = 32'(sel_tot);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data.probability <= ld_prob;
      out_data.pair_count  <= cnt32[19:0];
      out_data.row_total   <= tot32[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        idx <= (idx == PAW'(PAIR_DEPTH - 1)) ? '0 : idx + PAW'(1);
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tptc_checker.sv -----
// Port-level checker for the tile pair transition counter and its bind.
`default_nettype none
module tptc_checker
  import tptc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      push,
  input wire in_item_t  in_data,
  input wire logic      full,
  input wire logic      pop,
  input wire out_item_t out_data,
  input wire logic      empty
);
  // Reset starts the table sweep, so no item may enter right after it.
  a_reset_blocks: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  // A new result is only loaded into an empty output register.
  a_pop_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("result appeared in the same cycle as a pop");

  // After a tile sample is accepted, full stays high while the front writes the line buffer.
  a_sample_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (push && !full && in_data.opcode == OP_SAMPLE) |=> full)
    else $error("item accepted during line buffer access");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");
endmodule

bind tile_pair_transition_counter_core tptc_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .in_data (in_data),
  .full    (full),
  .pop     (pop),
  .out_data(out_data),
  .empty   (empty)
);
`default_nettype wire
